@@ src/rcda_pkg.sv @@
// rcda_pkg: shared types and constants for the reactive collector drive arbiter.
// No dependencies; every other file in src uses it by scoped names.
package rcda_pkg;

    localparam int SENSOR_W   = 12;
    localparam int LEVEL_W    = 12;
    localparam int TICK_W     = 8;
    localparam int SPEED_W    = 11;
    localparam int MODE_W     = 2;
    localparam int NUM_PROX   = 8;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam int FULL_SPEED = 1000;

    typedef logic signed [SPEED_W-1:0] speed_t;
    typedef logic [TICK_W-1:0]         tick_t;
    typedef logic [LEVEL_W-1:0]        level_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_TURN   = 2'd0,
        MODE_PUSH   = 2'd1,
        MODE_SEARCH = 2'd2
    } mode_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_BLACK  = 2'd0,
        REG_PUSH   = 2'd1,
        REG_DETECT = 2'd2,
        REG_TURN   = 2'd3
    } reg_idx_t;

    localparam speed_t SPD_FULL = SPEED_W'(FULL_SPEED);
    localparam speed_t SPD_NEG  = SPEED_W'(-FULL_SPEED);
    localparam speed_t SPD_ZERO = SPEED_W'(0);
    localparam speed_t SPD_9    = SPEED_W'(FULL_SPEED * 9 / 10);
    localparam speed_t SPD_7    = SPEED_W'(FULL_SPEED * 7 / 10);
    localparam speed_t SPD_6    = SPEED_W'(FULL_SPEED * 6 / 10);
    localparam speed_t SPD_3    = SPEED_W'(FULL_SPEED * 3 / 10);
    localparam speed_t SPD_1    = SPEED_W'(FULL_SPEED * 1 / 10);

    // turn-around down-counters
    typedef struct packed {
        tick_t left_cnt;
        tick_t right_cnt;
    } turn_t;

    // thresholds handed to the merge stage
    typedef struct packed {
        level_t black_level;
        level_t push_level;
        tick_t  turn_ticks;
    } merge_cfg_t;

    typedef struct packed {
        speed_t left_speed;
        speed_t right_speed;
        mode_t  mode;
    } drive_t;

endpackage

@@ src/rcda_if.sv @@
// rcda_if: valid/ready channel interfaces for sensor frames and drive words.
// Depends on rcda_pkg.
interface rcda_in_if;
    logic                           valid;
    logic                           ready;
    logic [rcda_pkg::SENSOR_W-1:0]  prox_0;
    logic [rcda_pkg::SENSOR_W-1:0]  prox_1;
    logic [rcda_pkg::SENSOR_W-1:0]  prox_2;
    logic [rcda_pkg::SENSOR_W-1:0]  prox_3;
    logic [rcda_pkg::SENSOR_W-1:0]  prox_4;
    logic [rcda_pkg::SENSOR_W-1:0]  prox_5;
    logic [rcda_pkg::SENSOR_W-1:0]  prox_6;
    logic [rcda_pkg::SENSOR_W-1:0]  prox_7;
    logic [rcda_pkg::SENSOR_W-1:0]  ground_left;
    logic [rcda_pkg::SENSOR_W-1:0]  ground_mid;
    logic [rcda_pkg::SENSOR_W-1:0]  ground_right;

    modport source (
        output valid, prox_0, prox_1, prox_2, prox_3, prox_4, prox_5, prox_6, prox_7,
               ground_left, ground_mid, ground_right,
        input  ready
    );
    modport sink (
        input  valid, prox_0, prox_1, prox_2, prox_3, prox_4, prox_5, prox_6, prox_7,
               ground_left, ground_mid, ground_right,
        output ready
    );
endinterface

interface rcda_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [rcda_pkg::SPEED_W-1:0] left_speed;
    logic signed [rcda_pkg::SPEED_W-1:0] right_speed;
    logic [rcda_pkg::MODE_W-1:0]   mode;

    modport source (
        output valid, left_speed, right_speed, mode,
        input  ready
    );
    modport sink (
        input  valid, left_speed, right_speed, mode,
        output ready
    );
endinterface

@@ src/reactive_collector_drive_arbiter_unit.sv @@
// reactive_collector_drive_arbiter_unit: top level, eight sensor lanes, merge, turn state,
// output register and APB register file. Depends on rcda_pkg, rcda_if, rcda_lane, rcda_merge.
//
//  channel  | dir | handshake     | word
//  ---------+-----+---------------+-------------------------------------------
//  sensor   | in  | valid/ready   | prox_0..prox_7, ground_left/mid/right
//  drive    | out | valid/ready   | left_speed, right_speed, mode
//  apb      | in  | psel/penable  | black, push, detect level, turn_ticks
//
//  One word per cycle while drive is not stalled; a frame is decided in the cycle it is taken
//  and lands in the output register, so its word is visible in the next cycle.
//  Throughput is set by the output register: sensor.ready = !drive.valid || drive.ready.
//  Reset clears the turn counters, the output valid and the registers to defaults.
module reactive_collector_drive_arbiter_unit #(
    parameter int SENSOR_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    rcda_in_if.sink                            sensor,
    rcda_out_if.source                         drive,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rcda_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rcda_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rcda_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int UW = (SENSOR_BITS < rcda_pkg::SENSOR_W) ? SENSOR_BITS : rcda_pkg::SENSOR_W;

    rcda_pkg::level_t  black_level_reg;
    rcda_pkg::level_t  push_level_reg;
    rcda_pkg::level_t  detect_level_reg;
    rcda_pkg::tick_t   turn_ticks_reg;
    rcda_pkg::turn_t   turn_reg;
    rcda_pkg::turn_t   turn_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    rcda_pkg::drive_t  drive_reg;
    rcda_pkg::drive_t  drive_next;

    logic [UW-1:0]                   prox [rcda_pkg::NUM_PROX];
    logic [rcda_pkg::NUM_PROX-1:0]   hits;
    rcda_pkg::merge_cfg_t            mcfg;
    logic                            accept;
    logic                            cfg_wr;
    rcda_pkg::reg_idx_t              reg_sel;

    assign prox[0] = sensor.prox_0[UW-1:0];
    assign prox[1] = sensor.prox_1[UW-1:0];
    assign prox[2] = sensor.prox_2[UW-1:0];
    assign prox[3] = sensor.prox_3[UW-1:0];
    assign prox[4] = sensor.prox_4[UW-1:0];
    assign prox[5] = sensor.prox_5[UW-1:0];
    assign prox[6] = sensor.prox_6[UW-1:0];
    assign prox[7] = sensor.prox_7[UW-1:0];

    genvar g;
    generate
        for (g = 0; g < rcda_pkg::NUM_PROX; g++)
        begin : g_lane
            rcda_lane #(
                .IDX (g),
                .W   (UW)
            ) u_lane (
                .prox         (prox),
                .detect_level (detect_level_reg),
                .hit          (hits[g])
            );
        end
    endgenerate

    assign mcfg.black_level = black_level_reg;
    assign mcfg.push_level  = push_level_reg;
    assign mcfg.turn_ticks  = turn_ticks_reg;

    rcda_merge #(
        .W (UW)
    ) u_merge (
        .hits         (hits),
        .prox_front_a (prox[0]),
        .prox_front_b (prox[7]),
        .gnd_left     (sensor.ground_left[UW-1:0]),
        .gnd_mid      (sensor.ground_mid[UW-1:0]),
        .gnd_right    (sensor.ground_right[UW-1:0]),
        .cfg          (mcfg),
        .turn_cur     (turn_reg),
        .turn_next    (turn_next),
        .drive        (drive_next)
    );

    assign sensor.ready   = !out_valid_reg || drive.ready;
    assign accept         = sensor.valid && sensor.ready;
    assign out_valid_next = accept || (out_valid_reg && !drive.ready);

    assign drive.valid       = out_valid_reg;
    assign drive.left_speed  = drive_reg.left_speed;
    assign drive.right_speed = drive_reg.right_speed;
    assign drive.mode        = drive_reg.mode;

    // APB
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = rcda_pkg::reg_idx_t'(paddr[rcda_pkg::APB_ADDR_W-1:2]);

    always_comb
    begin
        case (reg_sel)
            rcda_pkg::REG_BLACK:  prdata = rcda_pkg::APB_DATA_W'(black_level_reg);
            rcda_pkg::REG_PUSH:   prdata = rcda_pkg::APB_DATA_W'(push_level_reg);
            rcda_pkg::REG_DETECT: prdata = rcda_pkg::APB_DATA_W'(detect_level_reg);
            rcda_pkg::REG_TURN:   prdata = rcda_pkg::APB_DATA_W'(turn_ticks_reg);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_level_reg  <= rcda_pkg::LEVEL_W'(500);
            push_level_reg   <= rcda_pkg::LEVEL_W'(150);
            detect_level_reg <= rcda_pkg::LEVEL_W'(80);
            turn_ticks_reg   <= rcda_pkg::TICK_W'(10);
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                rcda_pkg::REG_BLACK:  black_level_reg  <= pwdata[rcda_pkg::LEVEL_W-1:0];
                rcda_pkg::REG_PUSH:   push_level_reg   <= pwdata[rcda_pkg::LEVEL_W-1:0];
                rcda_pkg::REG_DETECT: detect_level_reg <= pwdata[rcda_pkg::LEVEL_W-1:0];
                rcda_pkg::REG_TURN:   turn_ticks_reg   <= pwdata[rcda_pkg::TICK_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                turn_reg <= turn_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            drive_reg <= drive_next;
        end
    end

endmodule

@@ src/rcda_lane.sv @@
// rcda_lane: one proximity lane; flags its sensor as a search maximum above detect level.
// Depends on rcda_pkg.
module rcda_lane #(
    parameter int IDX = 0,
    parameter int W   = 12
) (
    input  logic [W-1:0]                  prox [rcda_pkg::NUM_PROX],
    input  logic [rcda_pkg::LEVEL_W-1:0]  detect_level,
    output logic                          hit
);

    logic is_max;

    always_comb
    begin
        is_max = 1'b1;
        for (int j = 0; j < rcda_pkg::NUM_PROX; j++)
        begin
            if (j != IDX && prox[IDX] < prox[j])
            begin
                is_max = 1'b0;
            end
        end
    end

    assign hit = is_max && (rcda_pkg::LEVEL_W'(prox[IDX]) > detect_level);

endmodule

@@ src/rcda_merge.sv @@
// rcda_merge: combines lane hits with turn, boundary and push priority into one drive word.
// Depends on rcda_pkg.
module rcda_merge #(
    parameter int W = 12
) (
    input  logic [rcda_pkg::NUM_PROX-1:0]  hits,
    input  logic [W-1:0]                   prox_front_a,
    input  logic [W-1:0]                   prox_front_b,
    input  logic [W-1:0]                   gnd_left,
    input  logic [W-1:0]                   gnd_mid,
    input  logic [W-1:0]                   gnd_right,
    input  rcda_pkg::merge_cfg_t           cfg,
    input  rcda_pkg::turn_t                turn_cur,
    output rcda_pkg::turn_t                turn_next,
    output rcda_pkg::drive_t               drive
);

    logic                  turning;
    logic                  boundary;
    logic                  go_left;
    rcda_pkg::tick_t       ticks;
    rcda_pkg::turn_t       turn_eff;
    logic                  pushing;
    rcda_pkg::level_t      fa;
    rcda_pkg::level_t      fb;

    assign fa = rcda_pkg::LEVEL_W'(prox_front_a);
    assign fb = rcda_pkg::LEVEL_W'(prox_front_b);

    assign turning  = (turn_cur.left_cnt != '0) || (turn_cur.right_cnt != '0);
    assign boundary = !turning
                      && (rcda_pkg::LEVEL_W'(gnd_left)  < cfg.black_level
                       || rcda_pkg::LEVEL_W'(gnd_mid)   < cfg.black_level
                       || rcda_pkg::LEVEL_W'(gnd_right) < cfg.black_level);
    assign go_left  = gnd_right > gnd_left;
    assign ticks    = (cfg.turn_ticks == '0) ? rcda_pkg::TICK_W'(1) : cfg.turn_ticks;
    assign pushing  = (fa > cfg.push_level) || (fb > cfg.push_level);

    always_comb
    begin
        turn_eff = turn_cur;
        if (boundary)
        begin
            if (go_left)
            begin
                turn_eff.left_cnt = ticks;
            end
            else
            begin
                turn_eff.right_cnt = ticks;
            end
        end

        turn_next         = turn_eff;
        drive.left_speed  = rcda_pkg::SPD_FULL;
        drive.right_speed = rcda_pkg::SPD_FULL;
        drive.mode        = rcda_pkg::MODE_SEARCH;

        if (turning || boundary)
        begin
            drive.mode = rcda_pkg::MODE_TURN;
            if (turn_eff.left_cnt != '0)
            begin
                turn_next.left_cnt = turn_eff.left_cnt - rcda_pkg::TICK_W'(1);
                drive.left_speed   = rcda_pkg::SPD_ZERO;
                drive.right_speed  = rcda_pkg::SPD_NEG;
            end
            else
            begin
                turn_next.right_cnt = turn_eff.right_cnt - rcda_pkg::TICK_W'(1);
                drive.left_speed    = rcda_pkg::SPD_NEG;
                drive.right_speed   = rcda_pkg::SPD_ZERO;
            end
        end
        else if (pushing)
        begin
            drive.mode = rcda_pkg::MODE_PUSH;
            if (fa > fb)
            begin
                drive.left_speed  = rcda_pkg::SPD_9;
                drive.right_speed = rcda_pkg::SPD_7;
            end
            else if (fa < fb)
            begin
                drive.left_speed  = rcda_pkg::SPD_7;
                drive.right_speed = rcda_pkg::SPD_9;
            end
        end
        else
        begin
            // later maxima overwrite earlier ones
            if (hits[0]) drive.right_speed = rcda_pkg::SPD_6;
            if (hits[1]) drive.right_speed = rcda_pkg::SPD_3;
            if (hits[2]) drive.right_speed = rcda_pkg::SPD_1;
            if (hits[5]) drive.left_speed  = rcda_pkg::SPD_1;
            if (hits[6]) drive.left_speed  = rcda_pkg::SPD_3;
            if (hits[7]) drive.left_speed  = rcda_pkg::SPD_6;
        end
    end

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for reactive_collector_drive_arbiter_unit; directed sensor frames,
// then randomized phases under several register settings. Depends on rcda_pkg, rcda_if, src RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT  = 400000;
    localparam int SETTLE = 4;
    localparam int SMAX   = (1 << rcda_pkg::SENSOR_W) - 1;

    localparam rcda_pkg::speed_t V_FULL = rcda_pkg::speed_t'(rcda_pkg::FULL_SPEED);
    localparam rcda_pkg::speed_t V_NEG  = rcda_pkg::speed_t'(-rcda_pkg::FULL_SPEED);
    localparam rcda_pkg::speed_t V_ZERO = rcda_pkg::speed_t'(0);
    localparam rcda_pkg::speed_t V9     = rcda_pkg::speed_t'(rcda_pkg::FULL_SPEED * 9 / 10);
    localparam rcda_pkg::speed_t V7     = rcda_pkg::speed_t'(rcda_pkg::FULL_SPEED * 7 / 10);
    localparam rcda_pkg::speed_t V6     = rcda_pkg::speed_t'(rcda_pkg::FULL_SPEED * 6 / 10);
    localparam rcda_pkg::speed_t V3     = rcda_pkg::speed_t'(rcda_pkg::FULL_SPEED * 3 / 10);
    localparam rcda_pkg::speed_t V1     = rcda_pkg::speed_t'(rcda_pkg::FULL_SPEED * 1 / 10);

    typedef struct packed {
        logic [rcda_pkg::NUM_PROX-1:0][rcda_pkg::SENSOR_W-1:0] prox;
        logic [rcda_pkg::SENSOR_W-1:0]                         gl;
        logic [rcda_pkg::SENSOR_W-1:0]                         gm;
        logic [rcda_pkg::SENSOR_W-1:0]                         gr;
    } frame_t;

    typedef struct {
        frame_t           f;
        int               reps;
        bit               known;
        rcda_pkg::drive_t want;
    } row_t;

    typedef struct {
        int black;
        int push;
        int detect;
        int ticks;
        int items;
        bit rnd;
        bit quiet;
    } phase_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [rcda_pkg::APB_ADDR_W-1:0] paddr;
    logic [rcda_pkg::APB_DATA_W-1:0] pwdata;
    logic [rcda_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    rcda_in_if  sensor_if ();
    rcda_out_if drive_if ();

    reactive_collector_drive_arbiter_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sensor  (sensor_if),
        .drive   (drive_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the block's registers and turn counters
    rcda_pkg::level_t black_lvl;
    rcda_pkg::level_t push_lvl;
    rcda_pkg::level_t detect_lvl;
    rcda_pkg::tick_t  turn_len;
    rcda_pkg::tick_t  cnt_left;
    rcda_pkg::tick_t  cnt_right;

    rcda_pkg::drive_t due_drive[$];
    rcda_pkg::drive_t head;
    int               mismatches  = 0;
    int               cycle_count = 0;
    int               ready_hold  = 0;
    bit               calm        = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    function automatic rcda_pkg::drive_t mk_drive(input rcda_pkg::speed_t l,
                                                  input rcda_pkg::speed_t r,
                                                  input rcda_pkg::mode_t m);
        rcda_pkg::drive_t d;
        d.left_speed  = l;
        d.right_speed = r;
        d.mode        = m;
        return d;
    endfunction

    function automatic frame_t frm(input int p0, input int p1, input int p2, input int p3,
                                   input int p4, input int p5, input int p6, input int p7,
                                   input int gl, input int gm, input int gr);
        frame_t f;
        f.prox[0] = p0[rcda_pkg::SENSOR_W-1:0];
        f.prox[1] = p1[rcda_pkg::SENSOR_W-1:0];
        f.prox[2] = p2[rcda_pkg::SENSOR_W-1:0];
        f.prox[3] = p3[rcda_pkg::SENSOR_W-1:0];
        f.prox[4] = p4[rcda_pkg::SENSOR_W-1:0];
        f.prox[5] = p5[rcda_pkg::SENSOR_W-1:0];
        f.prox[6] = p6[rcda_pkg::SENSOR_W-1:0];
        f.prox[7] = p7[rcda_pkg::SENSOR_W-1:0];
        f.gl      = gl[rcda_pkg::SENSOR_W-1:0];
        f.gm      = gm[rcda_pkg::SENSOR_W-1:0];
        f.gr      = gr[rcda_pkg::SENSOR_W-1:0];
        return f;
    endfunction

    function automatic row_t row(input frame_t f, input int reps, input bit known,
                                 input rcda_pkg::drive_t want);
        row_t r;
        r.f     = f;
        r.reps  = reps;
        r.known = known;
        r.want  = want;
        return r;
    endfunction

    // arbitration: turn-around, then boundary, then push, then search
    function automatic rcda_pkg::drive_t predict_drive(input frame_t f);
        rcda_pkg::drive_t w;
        logic             turning;
        rcda_pkg::tick_t  len;
        bit               is_top;
        int               i;
        int               j;
        turning = (cnt_left != 0) || (cnt_right != 0);
        if (!turning && (f.gl < black_lvl || f.gm < black_lvl || f.gr < black_lvl))
        begin
            len = (turn_len != 0) ? turn_len : rcda_pkg::tick_t'(1);
            if (f.gr > f.gl)
                cnt_left = len;
            else
                cnt_right = len;
            turning = 1'b1;
        end
        if (turning)
        begin
            if (cnt_left != 0)
            begin
                cnt_left = cnt_left - 1'b1;
                w = mk_drive(V_ZERO, V_NEG, rcda_pkg::MODE_TURN);
            end
            else
            begin
                cnt_right = cnt_right - 1'b1;
                w = mk_drive(V_NEG, V_ZERO, rcda_pkg::MODE_TURN);
            end
        end
        else if (f.prox[0] > push_lvl || f.prox[7] > push_lvl)
        begin
            if (f.prox[0] > f.prox[7])
                w = mk_drive(V9, V7, rcda_pkg::MODE_PUSH);
            else if (f.prox[0] < f.prox[7])
                w = mk_drive(V7, V9, rcda_pkg::MODE_PUSH);
            else
                w = mk_drive(V_FULL, V_FULL, rcda_pkg::MODE_PUSH);
        end
        else
        begin
            w = mk_drive(V_FULL, V_FULL, rcda_pkg::MODE_SEARCH);
            for (i = 0; i < rcda_pkg::NUM_PROX; i++)
            begin
                is_top = 1'b1;
                for (j = 0; j < rcda_pkg::NUM_PROX; j++)
                    if (j != i && f.prox[i] < f.prox[j])
                        is_top = 1'b0;
                if (is_top && f.prox[i] > detect_lvl)
                begin
                    case (i)
                        0: w.right_speed = V6;
                        1: w.right_speed = V3;
                        2: w.right_speed = V1;
                        5: w.left_speed  = V1;
                        6: w.left_speed  = V3;
                        7: w.left_speed  = V6;
                        default: ;
                    endcase
                end
            end
        end
        return w;
    endfunction

    function automatic logic [rcda_pkg::SENSOR_W-1:0] near_level(input int lvl);
        int v;
        v = lvl + int'($urandom_range(2, 0)) - 1;
        if (v < 0)
            v = 0;
        if (v > SMAX)
            v = SMAX;
        return v[rcda_pkg::SENSOR_W-1:0];
    endfunction

    function automatic frame_t rand_frame();
        frame_t         f;
        int             kind;
        int             v;
        int             top;
        int             idx;
        int             i;
        logic [7:0]     sel;
        kind = $urandom_range(9, 0);
        f.gl = rcda_pkg::SENSOR_W'($urandom_range(SMAX, black_lvl));
        f.gm = rcda_pkg::SENSOR_W'($urandom_range(SMAX, black_lvl));
        f.gr = rcda_pkg::SENSOR_W'($urandom_range(SMAX, black_lvl));
        if (kind == 0)
        begin
            f.gl = rcda_pkg::SENSOR_W'($urandom());
            f.gm = rcda_pkg::SENSOR_W'($urandom());
            f.gr = rcda_pkg::SENSOR_W'($urandom());
        end
        else if (kind == 1 && black_lvl != 0)
        begin
            v = $urandom_range(black_lvl - 1, 0);
            case ($urandom_range(2, 0))
                0: f.gl = v[rcda_pkg::SENSOR_W-1:0];
                1: f.gm = v[rcda_pkg::SENSOR_W-1:0];
                default: f.gr = v[rcda_pkg::SENSOR_W-1:0];
            endcase
            if ($urandom_range(3, 0) == 0)
                f.gr = f.gl;
        end

        kind = $urandom_range(5, 0);
        case (kind)
            0:
            begin
                for (i = 0; i < rcda_pkg::NUM_PROX; i++)
                    f.prox[i] = rcda_pkg::SENSOR_W'($urandom());
            end
            1:
            begin
                for (i = 0; i < rcda_pkg::NUM_PROX; i++)
                    f.prox[i] = rcda_pkg::SENSOR_W'($urandom_range(255, 0));
            end
            2:
            begin
                // one or more sensors set to the maximum
                v = $urandom_range(1, 0) ? int'(near_level(detect_lvl)) : $urandom_range(SMAX, 0);
                sel = 8'($urandom_range(255, 1));
                for (i = 0; i < rcda_pkg::NUM_PROX; i++)
                    f.prox[i] = sel[i] ? v[rcda_pkg::SENSOR_W-1:0]
                                       : rcda_pkg::SENSOR_W'($urandom_range(v, 0));
            end
            3:
            begin
                for (i = 0; i < rcda_pkg::NUM_PROX; i++)
                    f.prox[i] = rcda_pkg::SENSOR_W'($urandom());
                f.prox[0] = near_level(push_lvl);
                f.prox[7] = ($urandom_range(2, 0) == 0) ? f.prox[0] : near_level(push_lvl);
            end
            4:
            begin
                top = $urandom_range(SMAX, 0);
                idx = $urandom_range(rcda_pkg::NUM_PROX - 1, 0);
                for (i = 0; i < rcda_pkg::NUM_PROX; i++)
                    f.prox[i] = rcda_pkg::SENSOR_W'($urandom_range(top, 0));
                f.prox[idx] = top[rcda_pkg::SENSOR_W-1:0];
            end
            default:
            begin
                v = near_level(detect_lvl);
                for (i = 0; i < rcda_pkg::NUM_PROX; i++)
                    f.prox[i] = v[rcda_pkg::SENSOR_W-1:0];
            end
        endcase
        return f;
    endfunction

    task automatic send_frame(input frame_t f, input bit known, input rcda_pkg::drive_t want);
        int               gap;
        rcda_pkg::drive_t calc;
        gap = (!calm && $urandom_range(4, 0) == 0) ? $urandom_range(3, 1) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            sensor_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sensor_if.valid        <= 1'b1;
        sensor_if.prox_0       <= f.prox[0];
        sensor_if.prox_1       <= f.prox[1];
        sensor_if.prox_2       <= f.prox[2];
        sensor_if.prox_3       <= f.prox[3];
        sensor_if.prox_4       <= f.prox[4];
        sensor_if.prox_5       <= f.prox[5];
        sensor_if.prox_6       <= f.prox[6];
        sensor_if.prox_7       <= f.prox[7];
        sensor_if.ground_left  <= f.gl;
        sensor_if.ground_mid   <= f.gm;
        sensor_if.ground_right <= f.gr;
        do
            @(posedge clk);
        while (!sensor_if.ready);
        calc = predict_drive(f);
        due_drive.push_back(known ? want : calc);
    endtask

    task automatic quiesce();
        @(negedge clk);
        sensor_if.valid <= 1'b0;
        while (due_drive.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // write, then read back
    task automatic reg_write(input rcda_pkg::reg_idx_t idx, input int unsigned val);
        logic [rcda_pkg::APB_DATA_W-1:0] mask;
        logic [rcda_pkg::APB_DATA_W-1:0] stored;
        mask   = (idx == rcda_pkg::REG_TURN) ? rcda_pkg::APB_DATA_W'(8'hFF)
                                             : rcda_pkg::APB_DATA_W'(12'hFFF);
        stored = val & mask;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & ~mask) | stored;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            rcda_pkg::REG_BLACK:  black_lvl  = stored[rcda_pkg::LEVEL_W-1:0];
            rcda_pkg::REG_PUSH:   push_lvl   = stored[rcda_pkg::LEVEL_W-1:0];
            rcda_pkg::REG_DETECT: detect_lvl = stored[rcda_pkg::LEVEL_W-1:0];
            default:              turn_len   = stored[rcda_pkg::TICK_W-1:0];
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== stored)
            note_mismatch($sformatf("reg %s readback: expected 0x%0h got 0x%0h",
                                    idx.name(), stored, prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // drive side: random stall bursts
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            drive_if.ready <= 1'b0;
            ready_hold--;
        end
        else if (!calm && $urandom_range(5, 0) == 0)
        begin
            drive_if.ready <= 1'b0;
            ready_hold = $urandom_range(2, 0);
        end
        else
        begin
            drive_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else if (rst_n && drive_if.valid && drive_if.ready)
        begin
            if (due_drive.size() == 0)
            begin
                note_mismatch($sformatf("unexpected drive word %0d/%0d/%0d",
                                        drive_if.left_speed, drive_if.right_speed,
                                        drive_if.mode));
            end
            else
            begin
                head = due_drive.pop_front();
                if (drive_if.left_speed !== head.left_speed ||
                    drive_if.right_speed !== head.right_speed ||
                    drive_if.mode !== head.mode)
                    note_mismatch($sformatf("drive word: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                            head.left_speed, head.right_speed, head.mode,
                                            drive_if.left_speed, drive_if.right_speed,
                                            drive_if.mode));
            end
        end
    end

    initial
    begin
        row_t   walk[$];
        phase_t phases[$];
        phase_t ph;
        int     k;
        int     n;

        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        drive_if.ready         = 1'b0;
        sensor_if.valid        = 1'b0;
        sensor_if.prox_0       = '0;
        sensor_if.prox_1       = '0;
        sensor_if.prox_2       = '0;
        sensor_if.prox_3       = '0;
        sensor_if.prox_4       = '0;
        sensor_if.prox_5       = '0;
        sensor_if.prox_6       = '0;
        sensor_if.prox_7       = '0;
        sensor_if.ground_left  = '0;
        sensor_if.ground_mid   = '0;
        sensor_if.ground_right = '0;

        black_lvl  = 500;
        push_lvl   = 150;
        detect_lvl = 80;
        turn_len   = 10;
        cnt_left   = '0;
        cnt_right  = '0;

        walk = '{
            row(frm(0, 0, 0, 0, 0, 0, 0, 0, 4095, 4095, 4095), 1, 1,
                mk_drive(V_FULL, V_FULL, rcda_pkg::MODE_SEARCH)),
            row(frm(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095), 1, 1,
                mk_drive(V_FULL, V_FULL, rcda_pkg::MODE_PUSH)),
            row(frm(200, 0, 0, 0, 0, 0, 0, 100, 1000, 1000, 1000), 1, 1,
                mk_drive(V9, V7, rcda_pkg::MODE_PUSH)),
            // ground exactly at black level is not a boundary
            row(frm(100, 0, 0, 0, 0, 0, 0, 151, 500, 500, 500), 1, 1,
                mk_drive(V7, V9, rcda_pkg::MODE_PUSH)),
            // front pair tied at push level: search, both pulls apply
            row(frm(150, 0, 0, 0, 0, 0, 0, 150, 4095, 4095, 4095), 1, 1,
                mk_drive(V6, V6, rcda_pkg::MODE_SEARCH)),
            row(frm(0, 4095, 0, 0, 0, 0, 0, 0, 4095, 4095, 4095), 1, 1,
                mk_drive(V_FULL, V3, rcda_pkg::MODE_SEARCH)),
            row(frm(0, 0, 81, 0, 0, 0, 0, 0, 4095, 4095, 4095), 1, 1,
                mk_drive(V_FULL, V1, rcda_pkg::MODE_SEARCH)),
            row(frm(0, 0, 0, 0, 0, 2000, 0, 0, 4095, 4095, 4095), 1, 1,
                mk_drive(V1, V_FULL, rcda_pkg::MODE_SEARCH)),
            row(frm(0, 0, 0, 0, 0, 0, 4095, 0, 4095, 4095, 4095), 1, 1,
                mk_drive(V3, V_FULL, rcda_pkg::MODE_SEARCH)),
            row(frm(0, 0, 0, 4095, 0, 0, 0, 0, 4095, 4095, 4095), 1, 1,
                mk_drive(V_FULL, V_FULL, rcda_pkg::MODE_SEARCH)),
            row(frm(0, 0, 0, 0, 80, 0, 0, 0, 4095, 4095, 4095), 1, 1,
                mk_drive(V_FULL, V_FULL, rcda_pkg::MODE_SEARCH)),
            // four-way tie, later sensors win
            row(frm(0, 90, 90, 0, 0, 90, 90, 0, 4095, 4095, 4095), 1, 1,
                mk_drive(V3, V1, rcda_pkg::MODE_SEARCH)),
            row(frm(12'hAAA, 12'h555, 12'h800, 12'h7FF, 12'h001, 12'hFFE, 12'h123, 12'h0F0,
                    12'hFFF, 12'hF00, 12'h2FF), 1, 0, '0),
            row(frm(0, 0, 0, 0, 0, 0, 0, 0, 499, 4095, 4095), 1, 1,
                mk_drive(V_ZERO, V_NEG, rcda_pkg::MODE_TURN)),
            // turn continues regardless of sensors
            row(frm(4095, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 9, 1,
                mk_drive(V_ZERO, V_NEG, rcda_pkg::MODE_TURN)),
            row(frm(12'h555, 12'hAAA, 12'h7FF, 12'h800, 12'hFFE, 12'h001, 12'h0F0, 12'h123,
                    500, 500, 12'hFFF), 1, 0, '0),
            // equal outer grounds turn right
            row(frm(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1,
                mk_drive(V_NEG, V_ZERO, rcda_pkg::MODE_TURN))
        };

        phases = '{
            '{500, 150, 80, 10, 220, 1'b0, 1'b0},
            '{0, 4095, 0, 1, 150, 1'b0, 1'b0},
            '{4095, 0, 4095, 0, 150, 1'b0, 1'b0},
            '{0, 0, 0, 0, 130, 1'b1, 1'b0},
            '{0, 0, 0, 0, 130, 1'b1, 1'b0},
            '{0, 0, 0, 0, 130, 1'b1, 1'b0},
            '{0, 0, 0, 0, 130, 1'b1, 1'b0},
            '{1000, 2000, 500, 255, 130, 1'b0, 1'b1}
        };

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        foreach (walk[k])
            for (n = 0; n < walk[k].reps; n++)
                send_frame(walk[k].f, walk[k].known, walk[k].want);

        foreach (phases[k])
        begin
            ph = phases[k];
            if (ph.rnd)
            begin
                ph.black  = $urandom_range(1500, 0);
                ph.push   = $urandom_range(2000, 0);
                ph.detect = $urandom_range(600, 0);
                ph.ticks  = $urandom_range(12, 0);
            end
            quiesce();
            reg_write(rcda_pkg::REG_BLACK, ph.black);
            reg_write(rcda_pkg::REG_PUSH, ph.push);
            reg_write(rcda_pkg::REG_DETECT, ph.detect);
            reg_write(rcda_pkg::REG_TURN, ph.ticks);
            calm = ph.quiet;
            for (n = 0; n < ph.items; n++)
                send_frame(rand_frame(), 1'b0, '0);
        end

        quiesce();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
